@@ rtl/spea_pkg.sv @@
// ============================================================================
// spea_pkg - shared definitions for the sinusoidal position embedding adder
// Field widths, fixed-point constants, CORDIC angle table, stage payload
// types and the build-time pair frequency function.
// ============================================================================
package spea_pkg;

    // Default configuration
    localparam int HIDDEN_DEF       = 512;
    localparam int MAX_POS_DEF      = 512;
    localparam int CORDIC_STEPS_DEF = 16;

    // Field widths
    localparam int POS_W       = 9;
    localparam int CH_W        = 9;
    localparam int ACT_W       = 16;
    localparam int SUM_W       = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Datapath widths
    localparam int PHASE_W = 32;
    localparam int FREQ_W  = 32;
    localparam int XY_W    = 32;
    localparam int ROUND_SHIFT = 18;
    localparam int ENC_W   = XY_W - ROUND_SHIFT;

    // Fixed-point constants
    localparam logic [63:0] LN10000_Q32 = 64'd39558110683;
    localparam logic [63:0] LN2_Q32     = 64'd2977044472;
    localparam logic [63:0] INV2PI_Q32  = 64'd683565276;
    localparam int          TAYLOR_TERMS = 16;
    localparam logic signed [XY_W-1:0] GAIN_Q30   = 32'sd652032875;
    localparam logic signed [XY_W-1:0] ROUND_BIAS = 32'sd131072;

    // Quadrant codes from the top two phase bits
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // Arctangent of 2^-i in Q0.32 turns
    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                    cos_sel;
        logic [PHASE_W-1:0]      phase;
        logic signed [ACT_W-1:0] activation;
    } cordic_in_t;

    typedef struct packed {
        logic signed [ENC_W-1:0] enc;
        logic signed [ACT_W-1:0] activation;
    } cordic_out_t;

    typedef struct packed {
        logic                    saturated;
        logic signed [SUM_W-1:0] sum;
    } result_t;

    // Frequency in Q0.32 turns per position from the scaled exponent
    // e = k * ln(10000) / HIDDEN in Q32. Evaluated at elaboration only.
    function automatic logic [FREQ_W-1:0] pair_freq(input logic [63:0] e);
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] scaled;
        n    = e / LN2_Q32;
        t    = LN2_Q32 - (e - n * LN2_Q32);
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int i = 1; i <= TAYLOR_TERMS; i++)
        begin
            term = ((term * t) >> 32) / 64'(i);
            acc  = acc + term;
        end
        scaled = (acc * INV2PI_Q32) >> 32;
        if (n >= 64'd63)
        begin
            return '0;
        end
        return FREQ_W'(scaled >> (n + 64'd1));
    endfunction

endpackage

@@ rtl/sinusoidal_position_embedding_add.sv @@
// ============================================================================
// sinusoidal_position_embedding_add - adds the sinusoidal position encoding
// Streams activations and adds sin or cos of position times a per-pair
// frequency, with saturation to signed Q3.12.
// ============================================================================
// Usage:
//   Input transfers on s_* carry position, channel and activation; each
//   produces exactly one output transfer on m_* with the saturated sum in
//   m_tdata and the clip flag in m_tuser, in input order.
//   Throughput is one item per cycle while s_tready is high. Each item
//   passes through index reduction, a frequency table read, a phase
//   multiply, the CORDIC micro-rotations, a rounding stage and a write
//   into the output queue before it can be presented on m_*.
//   The pipeline never stalls. A result queue of the next power of two at or
//   above CORDIC_STEPS + 7 entries absorbs receiver back-pressure, and
//   s_tready drops only when queued plus in-flight items fill that queue,
//   so a stalled receiver loses nothing and the input keeps flowing until
//   then.
//   Reset empties the pipeline and the queue; the frequency table is a
//   constant and needs no loading.
// ============================================================================
module sinusoidal_position_embedding_add #(
    parameter int HIDDEN        = spea_pkg::HIDDEN_DEF,
    parameter int MAX_POSITIONS = spea_pkg::MAX_POS_DEF,
    parameter int CORDIC_STEPS  = spea_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [8:0] position, [17:9] channel, [33:18] activation, [39:34] zero
    input  logic [spea_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] sum
    output logic [spea_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [0] saturated
    output logic                                 m_tuser
);

    import spea_pkg::*;

    localparam int PAIRS     = (HIDDEN + 1) / 2;
    localparam int PAIR_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ROM_DEPTH = 1 << PAIR_W;
    localparam int LATENCY   = CORDIC_STEPS + 6;
    localparam int Q_DEPTH   = 1 << $clog2(LATENCY + 1);
    localparam int TOT_W     = SUM_W + 1;

    logic                    accept;
    logic [POS_W-1:0]        pos_in;
    logic [CH_W-1:0]         ch_in;
    logic [POS_W-1:0]        pos_mod;
    logic [CH_W-1:0]         ch_mod;
    logic [PAIR_W-1:0]       pair_idx;

    logic [FREQ_W-1:0]       freq_rom [ROM_DEPTH];

    logic [3:0]              valid_reg;
    logic signed [ACT_W-1:0] act1_reg;
    logic signed [ACT_W-1:0] act2_reg;
    logic signed [ACT_W-1:0] act3_reg;
    logic signed [ACT_W-1:0] act4_reg;
    logic [POS_W-1:0]        pos3_reg;
    logic                    cos3_reg;
    logic                    cos4_reg;
    logic [FREQ_W-1:0]       freq_reg;
    logic [PHASE_W-1:0]      phase_reg;

    cordic_in_t              cord_in;
    logic                    cord_valid;
    cordic_out_t             cord_out;

    logic signed [TOT_W-1:0] total;
    logic                    clip;
    result_t                 res;
    result_t                 q_data;

    assign accept = s_tvalid & s_tready;
    assign pos_in = s_tdata[POS_W-1:0];
    assign ch_in  = s_tdata[POS_W+CH_W-1:POS_W];

    // Per-pair frequency table built at elaboration
    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        if (g < PAIRS)
        begin : g_used
            localparam logic [63:0] PairE =
                (64'(2 * g) * LN10000_Q32) / 64'(HIDDEN);
            localparam logic [FREQ_W-1:0] PairF = pair_freq(PairE);
            assign freq_rom[g] = PairF;
        end
        else
        begin : g_pad
            assign freq_rom[g] = '0;
        end
    end

    spea_modred #(
        .MOD (MAX_POSITIONS),
        .W   (POS_W)
    ) u_pos_mod (
        .clk (clk),
        .x   (pos_in),
        .r   (pos_mod)
    );

    spea_modred #(
        .MOD (HIDDEN),
        .W   (CH_W)
    ) u_ch_mod (
        .clk (clk),
        .x   (ch_in),
        .r   (ch_mod)
    );

    assign pair_idx = PAIR_W'(ch_mod >> 1);

    always_ff @(posedge clk)
    begin
        act1_reg  <= $signed(s_tdata[POS_W+CH_W+ACT_W-1:POS_W+CH_W]);
        act2_reg  <= act1_reg;
        // Table read, then phase = position * frequency modulo one turn
        freq_reg  <= freq_rom[pair_idx];
        pos3_reg  <= pos_mod;
        cos3_reg  <= ch_mod[0];
        act3_reg  <= act2_reg;
        phase_reg <= PHASE_W'((POS_W + FREQ_W)'(pos3_reg) * (POS_W + FREQ_W)'(freq_reg));
        cos4_reg  <= cos3_reg;
        act4_reg  <= act3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], accept};
        end
    end

    assign cord_in.cos_sel    = cos4_reg;
    assign cord_in.phase      = phase_reg;
    assign cord_in.activation = act4_reg;

    spea_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[3]),
        .in_data   (cord_in),
        .out_valid (cord_valid),
        .out_data  (cord_out)
    );

    // Add and clip to the signed 16-bit range
    assign total = TOT_W'(cord_out.activation) + TOT_W'(cord_out.enc);
    assign clip  = total[TOT_W-1] ^ total[TOT_W-2];

    always_comb
    begin
        res.saturated = clip;
        if (!clip)
        begin
            res.sum = total[SUM_W-1:0];
        end
        else if (total[TOT_W-1])
        begin
            res.sum = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            res.sum = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    spea_outq #(
        .DEPTH (Q_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .admit    (accept),
        .room     (s_tready),
        .wr_valid (cord_valid),
        .wr_data  (res),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (q_data)
    );

    assign m_tdata = q_data.sum;
    assign m_tuser = q_data.saturated;

endmodule

@@ rtl/spea_modred.sv @@
// ============================================================================
// spea_modred - two-stage reduction of a narrow index modulo a constant
// Multiplies by a floor reciprocal, then subtracts the quotient multiple and
// corrects once.
// ============================================================================
module spea_modred #(
    parameter int MOD = 512,
    parameter int W   = 9
) (
    input  logic         clk,
    input  logic [W-1:0] x,
    output logic [W-1:0] r
);

    localparam int SHIFT = 20;
    localparam int RW    = SHIFT + 1;
    localparam int PW    = W + RW;
    localparam int MW    = ((W > 17) ? W : 17) + 1;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / 64'(MOD));
    localparam logic [MW-1:0] MODC  = MW'(MOD);

    logic [W-1:0]    x_reg;
    logic [PW-1:0]   prod_reg;
    logic [W-1:0]    q;
    logic [W+MW-1:0] qm;
    logic [W-1:0]    r_est;
    logic [W-1:0]    r_next;
    logic [W-1:0]    r_reg;

    always_ff @(posedge clk)
    begin
        x_reg    <= x;
        prod_reg <= PW'(x) * PW'(RECIP);
    end

    // Quotient estimate is exact or one low, so the remainder is below 2*MOD
    assign q      = W'(prod_reg >> SHIFT);
    assign qm     = (W + MW)'(q) * (W + MW)'(MODC);
    assign r_est  = x_reg - W'(qm);
    assign r_next = (MW'(r_est) >= MODC) ? (r_est - W'(MODC)) : r_est;

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign r = r_reg;

endmodule

@@ rtl/spea_cordic.sv @@
// ============================================================================
// spea_cordic - pipelined rotation-mode CORDIC with quadrant unfolding
// One micro-rotation per stage, then a stage that picks sine or cosine by
// quadrant and rounds Q1.30 down to Q1.12.
// ============================================================================
module spea_cordic #(
    parameter int STEPS = spea_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  spea_pkg::cordic_in_t  in_data,
    output logic                  out_valid,
    output spea_pkg::cordic_out_t out_data
);

    import spea_pkg::*;

    logic signed [XY_W-1:0]  x_in   [STEPS];
    logic signed [XY_W-1:0]  y_in   [STEPS];
    logic signed [XY_W-1:0]  z_in   [STEPS];
    logic signed [XY_W-1:0]  x_next [STEPS];
    logic signed [XY_W-1:0]  y_next [STEPS];
    logic signed [XY_W-1:0]  z_next [STEPS];
    logic signed [XY_W-1:0]  x_reg  [STEPS];
    logic signed [XY_W-1:0]  y_reg  [STEPS];
    logic signed [XY_W-1:0]  z_reg  [STEPS];
    logic [1:0]              quad_reg [STEPS];
    logic                    cos_reg  [STEPS];
    logic signed [ACT_W-1:0] act_reg  [STEPS];
    logic [STEPS-1:0]        valid_reg;

    logic signed [XY_W-1:0]  c_val;
    logic signed [XY_W-1:0]  s_val;
    logic signed [XY_W-1:0]  v_sel;
    logic signed [XY_W-1:0]  v_round;
    cordic_out_t             out_next;
    cordic_out_t             out_reg;
    logic                    out_valid_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            assign x_in[i] = GAIN_Q30;
            assign y_in[i] = '0;
            assign z_in[i] = $signed({2'b00, in_data.phase[PHASE_W-3:0]});
        end
        else
        begin : g_rest
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_in[i] = z_reg[i-1];
        end

        // Rotate toward zero residual angle
        assign x_next[i] = z_in[i][XY_W-1] ? (x_in[i] + (y_in[i] >>> i))
                                           : (x_in[i] - (y_in[i] >>> i));
        assign y_next[i] = z_in[i][XY_W-1] ? (y_in[i] - (x_in[i] >>> i))
                                           : (y_in[i] + (x_in[i] >>> i));
        assign z_next[i] = z_in[i][XY_W-1] ? (z_in[i] + $signed(ATAN_TURNS[i]))
                                           : (z_in[i] - $signed(ATAN_TURNS[i]));
    end

    always_ff @(posedge clk)
    begin
        quad_reg[0] <= in_data.phase[PHASE_W-1:PHASE_W-2];
        cos_reg[0]  <= in_data.cos_sel;
        act_reg[0]  <= in_data.activation;
        for (int i = 0; i < STEPS; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
        for (int i = 1; i < STEPS; i++)
        begin
            quad_reg[i] <= quad_reg[i-1];
            cos_reg[i]  <= cos_reg[i-1];
            act_reg[i]  <= act_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[STEPS-2:0], in_valid};
            out_valid_reg <= valid_reg[STEPS-1];
        end
    end

    assign c_val = x_reg[STEPS-1];
    assign s_val = y_reg[STEPS-1];

    // Unfold the first-quadrant result to the full turn
    always_comb
    begin
        case (quad_reg[STEPS-1])
            QUAD_I:   v_sel = cos_reg[STEPS-1] ? c_val : s_val;
            QUAD_II:  v_sel = cos_reg[STEPS-1] ? -s_val : c_val;
            QUAD_III: v_sel = cos_reg[STEPS-1] ? -c_val : -s_val;
            QUAD_IV:  v_sel = cos_reg[STEPS-1] ? s_val : -c_val;
            default:  v_sel = c_val;
        endcase
    end

    assign v_round             = v_sel + ROUND_BIAS;
    assign out_next.enc        = v_round[XY_W-1:ROUND_SHIFT];
    assign out_next.activation = act_reg[STEPS-1];

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/spea_outq.sv @@
// ============================================================================
// spea_outq - output queue with admission credit
// Holds finished results for the receiver and admits a new item only while
// every item in flight is sure to find a free entry.
// ============================================================================
module spea_outq #(
    parameter int DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              admit,
    output logic              room,
    input  logic              wr_valid,
    input  spea_pkg::result_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output spea_pkg::result_t rd_data
);

    import spea_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    result_t       mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] level_reg;
    logic [CW-1:0] level_next;
    logic [CW-1:0] credit_reg;
    logic [CW-1:0] credit_next;
    logic          rd_fire;

    assign rd_valid    = (level_reg != '0);
    assign rd_fire     = rd_valid & rd_ready;
    assign room        = (credit_reg < CW'(DEPTH));
    assign level_next  = level_reg + CW'(wr_valid) - CW'(rd_fire);
    assign credit_next = credit_reg + CW'(admit) - CW'(rd_fire);

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (wr_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (rd_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            level_reg  <= level_next;
            credit_reg <= credit_next;
        end
    end

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CW'(DEPTH))
        else $error("admission credit above queue depth");

    a_level_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= credit_reg)
        else $error("queued results exceed admitted items");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid |-> (level_reg < CW'(DEPTH)))
        else $error("result written into a full queue");

    a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        (credit_reg == '0) |-> !wr_valid)
        else $error("result produced with no item in flight");
`endif

endmodule

@@ dv/sinusoidal_position_embedding_add_tb.sv @@
// ============================================================================
// sinusoidal_position_embedding_add_tb - stream test of the embedding adder
// Drives position/channel/activation transfers and predicts each saturated
// sum with a bit-exact CORDIC and frequency model. Every output transfer is
// checked in order against those predictions. Covers directed corners, random
// streams under sender and receiver idling, a long receiver stall and
// drain pauses.
// ============================================================================
module sinusoidal_position_embedding_add_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EMB_HIDDEN    = 512;
    localparam int EMB_MAX_POS   = 512;
    localparam int ROTATIONS     = 16;
    localparam int LATENCY       = ROTATIONS + 6;
    localparam int CLK_HALF      = 6;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int REPORT_MAX    = 60;

    localparam logic [63:0] LN10K_Q32    = 64'd39558110683;
    localparam logic [63:0] LN2_FIX_Q32  = 64'd2977044472;
    localparam logic [63:0] INV_2PI_Q32  = 64'd683565276;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032875;

    typedef struct packed {
        logic signed [15:0] sum;
        logic               saturated;
    } emb_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    // [8:0] position, [17:9] channel, [33:18] activation, [39:34] zero
    logic [spea_pkg::IN_TDATA_W-1:0]      s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    // [15:0] sum
    logic [spea_pkg::OUT_TDATA_W-1:0]     m_tdata;
    // [0] saturated
    logic                                 m_tuser;

    emb_result_t expected_sums[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_left = 0;

    sinusoidal_position_embedding_add #(
        .HIDDEN        (EMB_HIDDEN),
        .MAX_POSITIONS (EMB_MAX_POS),
        .CORDIC_STEPS  (ROTATIONS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic signed [63:0] atan_turns_q32(int i);
        case (i)
            0:       return 64'sh20000000;
            1:       return 64'sh12E4051E;
            2:       return 64'sh09FB385B;
            3:       return 64'sh051111D4;
            4:       return 64'sh028B0D43;
            5:       return 64'sh0145D7E1;
            6:       return 64'sh00A2F61E;
            7:       return 64'sh00517C55;
            8:       return 64'sh0028BE53;
            9:       return 64'sh00145F2F;
            10:      return 64'sh000A2F98;
            11:      return 64'sh000517CC;
            12:      return 64'sh00028BE6;
            13:      return 64'sh000145F3;
            14:      return 64'sh0000A2FA;
            15:      return 64'sh0000517D;
            16:      return 64'sh000028BE;
            17:      return 64'sh0000145F;
            18:      return 64'sh00000A30;
            19:      return 64'sh00000518;
            20:      return 64'sh0000028C;
            21:      return 64'sh00000146;
            22:      return 64'sh000000A3;
            23:      return 64'sh00000051;
            default: return 64'sh0;
        endcase
    endfunction

    // Turns per position for the even channel k of a sin/cos pair
    function automatic logic [31:0] freq_for_pair(logic [8:0] k);
        logic [63:0] expo;
        logic [63:0] octaves;
        logic [63:0] frac;
        logic [63:0] series;
        logic [63:0] term;
        logic [63:0] scaled;
        expo    = (64'(k) * LN10K_Q32) / 64'(EMB_HIDDEN);
        octaves = expo / LN2_FIX_Q32;
        frac    = LN2_FIX_Q32 - (expo - octaves * LN2_FIX_Q32);
        series  = 64'd1 << 32;
        term    = 64'd1 << 32;
        for (int i = 1; i <= 16; i++)
        begin
            term   = ((term * frac) >> 32) / 64'(i);
            series = series + term;
        end
        scaled = (series * INV_2PI_Q32) >> 32;
        if (octaves + 64'd1 >= 64'd64)
        begin
            return '0;
        end
        return 32'(scaled >> (octaves + 64'd1));
    endfunction

    // Sine or cosine of a Q0.32-turn phase, rounded to Q1.12
    function automatic logic signed [63:0] sinusoid_q312(logic [31:0] phase, logic want_cos);
        logic [1:0]          quad;
        logic signed [63:0]  x;
        logic signed [63:0]  y;
        logic signed [63:0]  z;
        logic signed [63:0]  nx;
        logic signed [63:0]  v;
        quad = phase[31:30];
        z    = $signed({34'd0, phase[29:0]});
        x    = CORDIC_GAIN;
        y    = '0;
        for (int i = 0; i < ROTATIONS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_turns_q32(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_turns_q32(i);
            end
            x = nx;
        end
        // Unfold the first-quadrant rotation into the full circle
        case (quad)
            spea_pkg::QUAD_I:   v = want_cos ? x : y;
            spea_pkg::QUAD_II:  v = want_cos ? -y : x;
            spea_pkg::QUAD_III: v = want_cos ? -x : -y;
            default:            v = want_cos ? y : -x;
        endcase
        return (v + 64'sd131072) >>> 18;
    endfunction

    function automatic emb_result_t predict_embedding(logic [8:0] pos, logic [8:0] ch,
                                                      logic signed [15:0] act);
        logic [8:0]          pos_m;
        logic [8:0]          ch_m;
        logic [63:0]         prod;
        logic signed [63:0]  total;
        emb_result_t         r;
        pos_m = 9'(int'(pos) % EMB_MAX_POS);
        ch_m  = 9'(int'(ch) % EMB_HIDDEN);
        prod  = 64'(pos_m) * 64'(freq_for_pair({ch_m[8:1], 1'b0}));
        total = sinusoid_q312(prod[31:0], ch_m[0]) + act;
        r.saturated = 1'b0;
        if (total > 64'sd32767)
        begin
            total       = 64'sd32767;
            r.saturated = 1'b1;
        end
        else if (total < -64'sd32768)
        begin
            total       = -64'sd32768;
            r.saturated = 1'b1;
        end
        r.sum = total[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking and watchdog
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_MAX)
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        emb_result_t want;
        if (rst_n)
        begin
            // Pop before push: a result can never belong to the same-edge input
            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing pending sum=%0d sat=%0b",
                                              $signed(m_tdata), m_tuser));
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want.sum)
                    begin
                        report_mismatch($sformatf("sum got %0d want %0d",
                                                  $signed(m_tdata), want.sum));
                    end
                    if (m_tuser !== want.saturated)
                    begin
                        report_mismatch($sformatf("saturated got %0b want %0b",
                                                  m_tuser, want.saturated));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_sums.push_back(predict_embedding(s_tdata[8:0], s_tdata[17:9],
                                                          $signed(s_tdata[33:18])));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_MAX)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready = 1'b0;
                rx_hold_left--;
            end
            else
            begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_embedding(input logic [8:0] pos, input logic [8:0] ch,
                                  input logic signed [15:0] act);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {6'd0, act, ch, pos};
        s_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    task automatic send_random_embedding();
        logic signed [15:0] act;
        case ($urandom_range(3))
            0:       act = 16'($urandom);
            1:       act = 16'(32767 - $urandom_range(8191));
            2:       act = 16'(-32768 + $urandom_range(8191));
            default: act = 16'($signed($urandom_range(8191)) - 4096);
        endcase
        send_embedding(9'($urandom), 9'($urandom), act);
    endtask

    // Drop valid, then hold until every pending result has arrived
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_embedding(9'd0, 9'd0, 16'sd0);
        send_embedding(9'd0, 9'd1, 16'sd0);
        send_embedding(9'd511, 9'd0, 16'sd0);
        send_embedding(9'd511, 9'd1, 16'sd0);
        // Walk the low pair through all four quadrants
        for (int p = 1; p <= 6; p++)
        begin
            send_embedding(9'(p), 9'd0, 16'sd100);
            send_embedding(9'(p), 9'd1, -16'sd100);
        end
        send_embedding(9'd511, 9'd510, 16'sd32767);
        send_embedding(9'd511, 9'd511, -16'sd32768);
        send_embedding(9'd255, 9'd510, -16'sd1);
        send_embedding(9'd256, 9'd511, 16'sd1);
        // Clip high on cos(0), clip low near a half turn, no clip on sin(0)
        send_embedding(9'd0, 9'd1, 16'sd32767);
        send_embedding(9'd3, 9'd1, -16'sd32768);
        send_embedding(9'd0, 9'd0, 16'sd32767);
        send_embedding(9'd0, 9'd0, -16'sd32768);
        drain_results();
    endtask

    task automatic test_random_stream(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_random_embedding();
        drain_results();
    endtask

    task automatic test_receiver_stall();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 300;
        repeat (80) send_random_embedding();
        drain_results();
    endtask

    task automatic test_sender_pause();
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        repeat (4)
        begin
            repeat (16) send_random_embedding();
            drain_results();
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_stream(220, 10, 63);
        test_random_stream(220, 63, 10);
        test_receiver_stall();
        test_sender_pause();
        test_random_stream(170, 0, 0);

        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
